### rtl/pidri_pkg.sv
// ----------------------------------------------------------------------------
// pidri_pkg
// Shared constants for the PID regulator with integral reset.
// ----------------------------------------------------------------------------
package pidri_pkg;

  // Depth of the error log used for the derivative mean
  localparam int LOG_DEPTH = 1;
  localparam int LOG_IDX_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int SUM_W     = 18 + ((LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 0);

  // Log mean by reciprocal multiplication; exact while sum * (MUL * DEPTH - 2^SH)
  // stays below 2^SH, which holds for a depth of up to 16
  localparam int     MEAN_SH  = SUM_W + 4;
  localparam longint MEAN_MUL = ((longint'(1) << MEAN_SH) + LOG_DEPTH - 1) / LOG_DEPTH;
  localparam int     MEAN_P_W = SUM_W + MEAN_SH + 1;

  // Configuration register indexes
  localparam logic [1:0] REG_KP    = 2'd0;
  localparam logic [1:0] REG_KI    = 2'd1;
  localparam logic [1:0] REG_KD    = 2'd2;
  localparam logic [1:0] REG_LIMIT = 2'd3;

  // Divider for the derivative: 27-bit dividend, elapsed time divisor
  localparam int DIV_W     = 27;
  localparam int DEN_W     = 10;
  localparam int CNT_W     = 5;

  // 1000 = 125 * 8, so x * 65536 / 1000 = x * 8192 / 125: split x into
  // 125 * q + r, then the word is q * 8192 + r * 8192 / 125
  localparam int     MS_ODD    = 125;
  localparam int     MS_ODD_SH = 13;
  localparam int     RCP_Q_SH  = 34;
  localparam longint RCP_Q_MUL = ((longint'(1) << RCP_Q_SH) + MS_ODD - 1) / MS_ODD;
  localparam int     RCP_F_SH  = 27;
  localparam longint RCP_F_MUL = ((longint'(1) << RCP_F_SH) + MS_ODD - 1) / MS_ODD;

  // Drive clamp
  localparam logic signed [27:0] DRIVE_MAX = 28'sd127;
  localparam logic signed [27:0] DRIVE_MIN = -28'sd127;

endpackage

### rtl/pid_regulator_integral_reset_unit.sv
// ----------------------------------------------------------------------------
// pid_regulator_integral_reset_unit
// PID position regulator: one drive word per sample, integral cleared on
// setpoint change, error sign change or when above the limit.
// ----------------------------------------------------------------------------
// The 27-step restoring divide by the elapsed time takes most of the time from
// accept to drive. One sample at a time: the next one is taken the cycle after
// the drive word is loaded, and a stalled drive word blocks the last step and so
// holds the next sample off. Reset clears gains, limit, integral, error history
// and setpoint.
module pid_regulator_integral_reset_unit
  import pidri_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] setpoint_i,
  input  logic signed [15:0] position_i,
  input  logic [9:0]         elapsed_ms_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [7:0]  drive_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SUM   = 4'd1;
  localparam logic [3:0] S_MEAN  = 4'd2;
  localparam logic [3:0] S_MULED = 4'd3;
  localparam logic [3:0] S_INCA  = 4'd4;
  localparam logic [3:0] S_INCB  = 4'd5;
  localparam logic [3:0] S_INCC  = 4'd6;
  localparam logic [3:0] S_ACC   = 4'd7;
  localparam logic [3:0] S_DIVD  = 4'd8;
  localparam logic [3:0] S_MP    = 4'd9;
  localparam logic [3:0] S_MI    = 4'd10;
  localparam logic [3:0] S_MD    = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;
  localparam logic [3:0] S_DRV   = 4'd13;

  logic [3:0] state_q, state_d;

  logic signed [15:0] kp_q, ki_q, kd_q;
  logic [15:0]        limit_q;

  logic signed [47:0] acc_q, acc_d;
  logic signed [17:0] prev_q, prev_d;
  logic signed [17:0] log_q [LOG_DEPTH];
  logic signed [17:0] log_d [LOG_DEPTH];
  logic signed [15:0] held_q, held_d;

  logic signed [17:0] err_q, err_d;
  logic [9:0]         dt_q, dt_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [LOG_IDX_W-1:0]    idx_q, idx_d;
  logic signed [18:0] diff_q, diff_d;
  logic signed [27:0] deriv_q, deriv_d;
  logic signed [49:0] prod_q, prod_d;
  logic signed [51:0] total_q, total_d;

  logic               drive_valid_q, drive_valid_d;
  logic signed [7:0]  drive_q, drive_d;

  // integral increment by reciprocal multiplication
  logic [20:0]        rcp_quo_q, rcp_quo_d;
  logic [6:0]         rcp_rem_q, rcp_rem_d;
  logic [33:0]        inc_mag_q, inc_mag_d;
  logic [54:0]        rcp_q_p;
  logic [27:0]        quo_x_odd;
  logic [40:0]        rcp_f_p;

  // divider
  logic              div_run_q, div_run_d;
  logic [CNT_W-1:0]  div_cnt_q, div_cnt_d;
  logic [DIV_W-1:0]  div_num_q, div_num_d;
  logic [DEN_W:0]    div_rem_q, div_rem_d;
  logic [DEN_W-1:0]  div_den_q, div_den_d;
  logic              div_neg_q, div_neg_d;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_sub;

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [49:0] mul_p;

  logic [SUM_W-1:0]   sum_mag;
  logic [MEAN_P_W-1:0] mean_p;
  logic [17:0]        mean_mag;
  logic [49:0]        prod_mag;
  logic [18:0]        diff_mag;
  logic signed [18:0] mean_s;
  logic signed [47:0] inc_s;
  logic signed [47:0] acc_new;
  logic [47:0]        acc_mag;
  logic               sign_diff;
  logic signed [51:0] prod_ext;
  logic signed [27:0] drv_t;
  logic               drv_adj;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = drive_valid_q;
  assign drive_o     = drive_q;

  assign mul_p    = mul_a * mul_b;
  assign sum_mag  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign prod_mag = prod_q[49] ? 50'(-prod_q) : 50'(prod_q);
  assign diff_mag = diff_q[18] ? 19'(-diff_q) : 19'(diff_q);
  assign prod_ext = {{2{prod_q[49]}}, prod_q};

  assign mean_p   = MEAN_P_W'(sum_mag) * MEAN_P_W'(MEAN_MUL);
  assign mean_mag = mean_p[MEAN_SH +: 18];

  assign rcp_q_p   = 55'(prod_mag[26:0]) * 55'(RCP_Q_MUL);
  assign quo_x_odd = 28'(rcp_quo_q) * 28'(MS_ODD);
  assign rcp_f_p   = (41'(rcp_rem_q) << MS_ODD_SH) * 41'(RCP_F_MUL);

  assign rem_sh  = {div_rem_q[DEN_W-1:0], div_num_q[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_den_q};

  assign mean_s = sum_q[SUM_W-1] ? -$signed({1'b0, mean_mag})
                                 : $signed({1'b0, mean_mag});
  assign inc_s  = prod_q[49] ? -$signed({14'b0, inc_mag_q})
                             : $signed({14'b0, inc_mag_q});
  assign acc_new = acc_q + inc_s;
  assign acc_mag = acc_new[47] ? 48'(-acc_new) : 48'(acc_new);
  assign sign_diff = ((prev_q == 18'sd0) != (err_q == 18'sd0)) ||
                     (prev_q[17] != err_q[17]);

  // truncate toward zero: floor, then bump negatives with a remainder
  assign drv_adj = total_q[51] && (total_q[23:0] != 24'd0);
  assign drv_t   = total_q[51:24] + 28'(drv_adj);

  always_comb begin
    state_d       = state_q;
    acc_d         = acc_q;
    prev_d        = prev_q;
    log_d         = log_q;
    held_d        = held_q;
    err_d         = err_q;
    dt_d          = dt_q;
    sum_d         = sum_q;
    idx_d         = idx_q;
    diff_d        = diff_q;
    deriv_d       = deriv_q;
    prod_d        = prod_q;
    total_d       = total_q;
    drive_d       = drive_q;
    drive_valid_d = drive_valid_q && out_stall_i;
    rcp_quo_d     = rcp_quo_q;
    rcp_rem_d     = rcp_rem_q;
    inc_mag_d     = inc_mag_q;
    div_run_d     = div_run_q;
    div_cnt_d     = div_cnt_q;
    div_num_d     = div_num_q;
    div_rem_d     = div_rem_q;
    div_den_d     = div_den_q;
    div_neg_d     = div_neg_q;
    mul_a         = 34'(err_q);
    mul_b         = kp_q;

    // one restoring step per cycle while the divider runs
    if (div_run_q && div_cnt_q != '0) begin
      div_cnt_d = div_cnt_q - CNT_W'(1);
      if (!rem_sub[DEN_W]) begin
        div_rem_d = rem_sub;
        div_num_d = {div_num_q[DIV_W-2:0], 1'b1};
      end else begin
        div_rem_d = rem_sh;
        div_num_d = {div_num_q[DIV_W-2:0], 1'b0};
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          err_d = 18'(setpoint_i) - 18'(position_i);
          dt_d  = (elapsed_ms_i == 10'd0) ? 10'd1 : elapsed_ms_i;
          if (setpoint_i != held_q) begin
            held_d = setpoint_i;
            acc_d  = '0;
          end
          sum_d   = '0;
          idx_d   = '0;
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        sum_d = sum_q + SUM_W'(log_q[idx_q]);
        idx_d = idx_q + LOG_IDX_W'(1);
        if (idx_q == LOG_IDX_W'(LOG_DEPTH - 1)) state_d = S_MEAN;
      end
      S_MEAN: begin
        diff_d  = 19'(err_q) - mean_s;
        state_d = S_MULED;
      end
      S_MULED: begin
        mul_a   = 34'(err_q);
        mul_b   = $signed({6'b0, dt_q});
        prod_d  = mul_p;
        state_d = S_INCA;
      end
      S_INCA: begin
        rcp_quo_d = rcp_q_p[RCP_Q_SH +: 21];
        state_d   = S_INCB;
      end
      S_INCB: begin
        rcp_rem_d = 7'(28'(prod_mag[26:0]) - quo_x_odd);
        state_d   = S_INCC;
      end
      S_INCC: begin
        inc_mag_d = {rcp_quo_q, rcp_f_p[RCP_F_SH +: MS_ODD_SH]};
        state_d   = S_ACC;
      end
      S_ACC: begin
        if (sign_diff || (acc_mag > {16'b0, limit_q, 16'b0})) acc_d = '0;
        else acc_d = acc_new;
        state_d = S_DIVD;
      end
      S_DIVD: begin
        if (!div_run_q) begin
          div_run_d = 1'b1;
          div_cnt_d = CNT_W'(DIV_W);
          div_num_d = DIV_W'({diff_mag, 8'b0});
          div_rem_d = '0;
          div_den_d = dt_q;
          div_neg_d = diff_q[18];
        end else if (div_cnt_q == '0) begin
          div_run_d = 1'b0;
          deriv_d   = div_neg_q ? -$signed({1'b0, div_num_q[26:0]})
                                : $signed({1'b0, div_num_q[26:0]});
          state_d   = S_MP;
        end
      end
      S_MP: begin
        mul_a   = 34'(err_q);
        mul_b   = kp_q;
        prod_d  = mul_p;
        total_d = '0;
        state_d = S_MI;
      end
      S_MI: begin
        mul_a   = acc_q[33:0];
        mul_b   = ki_q;
        prod_d  = mul_p;
        total_d = total_q + {prod_ext[35:0], 16'b0};
        state_d = S_MD;
      end
      S_MD: begin
        mul_a   = 34'(deriv_q);
        mul_b   = kd_q;
        prod_d  = mul_p;
        total_d = total_q + prod_ext;
        state_d = S_FIN;
      end
      S_FIN: begin
        total_d = total_q + {prod_ext[43:0], 8'b0};
        prev_d  = err_q;
        for (int k = 0; k < LOG_DEPTH - 1; k++) log_d[k] = log_q[k+1];
        log_d[LOG_DEPTH-1] = err_q;
        state_d = S_DRV;
      end
      S_DRV: begin
        // hold until the output register is free
        if (!drive_valid_q || !out_stall_i) begin
          if (drv_t > DRIVE_MAX)      drive_d = 8'sd127;
          else if (drv_t < DRIVE_MIN) drive_d = -8'sd127;
          else                        drive_d = drv_t[7:0];
          drive_valid_d = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      kp_q          <= '0;
      ki_q          <= '0;
      kd_q          <= '0;
      limit_q       <= '0;
      acc_q         <= '0;
      prev_q        <= '0;
      held_q        <= '0;
      drive_valid_q <= 1'b0;
      div_run_q     <= 1'b0;
      div_cnt_q     <= '0;
      for (int k = 0; k < LOG_DEPTH; k++) log_q[k] <= '0;
    end else begin
      state_q       <= state_d;
      acc_q         <= acc_d;
      prev_q        <= prev_d;
      held_q        <= held_d;
      log_q         <= log_d;
      drive_valid_q <= drive_valid_d;
      div_run_q     <= div_run_d;
      div_cnt_q     <= div_cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_KP:    kp_q    <= cfg_data_i;
          REG_KI:    ki_q    <= cfg_data_i;
          REG_KD:    kd_q    <= cfg_data_i;
          REG_LIMIT: limit_q <= cfg_data_i;
          default:   ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    err_q     <= err_d;
    dt_q      <= dt_d;
    sum_q     <= sum_d;
    idx_q     <= idx_d;
    diff_q    <= diff_d;
    deriv_q   <= deriv_d;
    prod_q    <= prod_d;
    total_q   <= total_d;
    drive_q   <= drive_d;
    rcp_quo_q <= rcp_quo_d;
    rcp_rem_q <= rcp_rem_d;
    inc_mag_q <= inc_mag_d;
    div_num_q <= div_num_d;
    div_rem_q <= div_rem_d;
    div_den_q <= div_den_d;
    div_neg_q <= div_neg_d;
  end

endmodule

### verif/tb_pid_regulator_integral_reset_unit.sv
// ----------------------------------------------------------------------------
// tb_pid_regulator_integral_reset_unit
// Self-checking bench: a cycle-free predictor computes the drive word of each
// accepted sample; a checker compares it against every word the block emits.
// ----------------------------------------------------------------------------
module tb_pid_regulator_integral_reset_unit;
  import pidri_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  LATENCY = LOG_DEPTH + DIV_W + 13;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int  HOLDOFF_LEN = 2000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [15:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [15:0] setpoint_i;
  logic signed [15:0] position_i;
  logic [9:0]         elapsed_ms_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [7:0]  drive_o;

  pid_regulator_integral_reset_unit dut (.*);

  // predictor state
  longint kp, ki, kd, ilimit;
  longint integ, last_err, held_sp;
  longint err_hist[LOG_DEPTH];

  logic signed [7:0] drive_queue[$];
  int     fail_cnt = 0;
  longint cycle_cnt = 0;
  int     holdoff_req = 0;
  int     holdoff_ack = 0;
  int     holdoff_cycles = 0;
  bit     stall_enable;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver stall: own random pattern plus long hold-off on request
  always @(posedge clk_i) begin
    if (holdoff_req != holdoff_ack) begin
      holdoff_ack    <= holdoff_req;
      holdoff_cycles <= HOLDOFF_LEN;
      out_stall_i    <= 1'b1;
    end else if (holdoff_cycles > 0) begin
      holdoff_cycles <= holdoff_cycles - 1;
      out_stall_i <= 1'b1;
    end else if (stall_enable) begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (drive_queue.size() == 0) begin
        $error("drive word %0d with nothing expected", drive_o);
        fail_cnt++;
      end else begin
        logic signed [7:0] exp_drive;
        exp_drive = drive_queue.pop_front();
        if (drive_o !== exp_drive) begin
          $error("drive: expected %0d, actual %0d", exp_drive, drive_o);
          fail_cnt++;
        end
      end
    end
  end

  function automatic int sgn(longint v);
    return (v > 0) - (v < 0);
  endfunction

  function automatic logic signed [7:0] predict_drive(logic signed [15:0] sp,
                                                      logic signed [15:0] pos,
                                                      logic [9:0] ms);
    longint dt, err, hsum, mean, deriv, mag, total, drv;
    dt = (ms == 0) ? 1 : longint'(ms);
    if (longint'(sp) != held_sp) begin
      held_sp = sp;
      integ   = 0;
    end
    err  = longint'(sp) - longint'(pos);
    hsum = 0;
    foreach (err_hist[k]) hsum += err_hist[k];
    mean = hsum / LOG_DEPTH;
    for (int k = 0; k + 1 < LOG_DEPTH; k++) err_hist[k] = err_hist[k + 1];
    err_hist[LOG_DEPTH - 1] = err;
    integ += (err * dt * 65536) / 1000;
    if (sgn(last_err) != sgn(err)) integ = 0;
    mag = (integ < 0) ? -integ : integ;
    if (mag > ilimit * 65536) integ = 0;
    deriv = ((err - mean) * 256) / dt;
    total = kp * err * 65536 + ki * integ + kd * deriv * 256;
    drv = total / (longint'(1) << 24);
    if (drv > 127) drv = 127;
    if (drv < -127) drv = -127;
    last_err = err;
    return 8'(drv);
  endfunction

  task automatic wait_idle();
    while (drive_queue.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_KP:    kp = longint'(signed'(val));
      REG_KI:    ki = longint'(signed'(val));
      REG_KD:    kd = longint'(signed'(val));
      REG_LIMIT: ilimit = longint'(val);
      default: ;
    endcase
  endtask

  task automatic set_gains(logic [15:0] p, logic [15:0] i, logic [15:0] d,
                           logic [15:0] lim);
    wait_idle();
    write_reg(REG_KP, p);
    write_reg(REG_KI, i);
    write_reg(REG_KD, d);
    write_reg(REG_LIMIT, lim);
  endtask

  // Offer one word and hold it until accepted; valid stays high afterwards
  task automatic send_sample(logic [15:0] sp, logic [15:0] pos, logic [9:0] ms);
    in_valid_i   <= 1'b1;
    setpoint_i   <= sp;
    position_i   <= pos;
    elapsed_ms_i <= ms;
    do @(posedge clk_i); while (in_stall_o);
    drive_queue.push_back(predict_drive(sp, pos, ms));
  endtask

  task automatic idle_sender(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic test_directed();
    set_gains(16'h0100, 16'h0080, 16'h0040, 16'd50);
    send_sample(16'sd100, 16'sd0, 10'd0);      // zero elapsed time
    send_sample(16'sd100, 16'sd10, 10'd1023);
    send_sample(16'sd100, 16'sd90, 10'd500);
    send_sample(16'sd100, 16'sd200, 10'd10);   // sign change of error
    send_sample(16'sd100, 16'sd100, 10'd10);   // zero error
    send_sample(16'sd100, 16'sd0, 10'd1023);   // integral over limit
    send_sample(16'sd100, 16'sd0, 10'd1023);
    send_sample(16'sd5, 16'sd0, 10'd1);        // setpoint change
    idle_sender(1);
    set_gains(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    send_sample(16'h7FFF, 16'h8000, 10'd1023); // saturated high
    send_sample(16'h8000, 16'h7FFF, 10'd0);    // saturated low
    send_sample(16'h8000, 16'h8000, 10'd1);
    send_sample(16'h0000, 16'hFFFF, 10'd512);
    idle_sender(1);
    set_gains(16'h8000, 16'h8000, 16'h8000, 16'd0);
    send_sample(16'h7FFF, 16'h8000, 10'd1023);
    send_sample(16'h7FFF, 16'h7FFE, 10'd3);
    send_sample(16'h8000, 16'h7FFF, 10'd0);
    send_sample(16'h1234, 16'h1233, 10'd7);
    idle_sender(1);
    set_gains(16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF);
    send_sample(16'sd1, 16'sd0, 10'd1000);
    send_sample(16'sd1, 16'sd0, 10'd1000);
    send_sample(16'sd1, -16'sd1, 10'd999);
    idle_sender(1);
  endtask

  task automatic run_random(int n_items);
    logic [15:0] sp, pos;
    logic [9:0]  ms;
    int burst;
    sp = 16'($urandom);
    burst = $urandom_range(1, 12);
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 7) == 0) sp = 16'($urandom);
      case ($urandom_range(0, 3))
        0:       pos = 16'($urandom);
        1:       pos = sp + 16'($urandom_range(0, 8)) - 16'd4;
        default: pos = sp + 16'($urandom_range(0, 400)) - 16'd200;
      endcase
      ms = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 20));
      send_sample(sp, pos, ms);
      if (--burst == 0) begin
        idle_sender($urandom_range(1, 200));
        burst = $urandom_range(1, 12);
      end
    end
    idle_sender(1);
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_gains(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        1: set_gains(16'h8000, 16'h8000, 16'h8000, 16'h0000);
        2: set_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        default: set_gains(16'($urandom_range(0, 1024)) - 16'd512,
                           16'($urandom_range(0, 4096)) - 16'd2048,
                           16'($urandom), $urandom_range(0, 3) == 0 ? 16'($urandom) :
                           16'($urandom_range(0, 200)));
      endcase
      stall_enable = (ph % 3 != 2);
      run_random(120);
    end
    stall_enable = 1'b1;
  endtask

  // Hold the output off while samples keep coming, so the input backs up
  task automatic test_backpressure();
    set_gains(16'h0200, 16'h0100, 16'h0010, 16'd1000);
    holdoff_req++;
    for (int k = 0; k < 30; k++)
      send_sample(16'($urandom_range(0, 50)), 16'($urandom_range(0, 50)),
                  10'($urandom_range(0, 30)));
    idle_sender(1);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0; setpoint_i = '0; position_i = '0; elapsed_ms_i = '0;
    stall_enable = 1'b1;
    kp = 0; ki = 0; kd = 0; ilimit = 0;
    integ = 0; last_err = 0; held_sp = 0;
    foreach (err_hist[k]) err_hist[k] = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    while (drive_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (fail_cnt == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
rtl/pidri_pkg.sv
rtl/pid_regulator_integral_reset_unit.sv
verif/tb_pid_regulator_integral_reset_unit.sv
